// ===== rtl/alb_pkg.sv =====
package alb_pkg;

  // Field widths of the item and result beats.
  localparam int FUNC_W = 2;
  localparam int IDX_W = 10;
  localparam int VAL_W = 32;
  localparam int CNT_W = 11;
  localparam int POS_W = 10;
  localparam int PRB_W = 4;
  localparam logic [PRB_W-1:0] PROBES_MAX = 4'd15;
  localparam logic [CNT_W-1:0] COUNT_RESET = 11'd1;

  // Operation codes carried in the item's tuser.
  typedef enum logic [FUNC_W-1:0] {
    FUNC_LOAD   = 2'd0,
    FUNC_LINEAR = 2'd1,
    FUNC_BINARY = 2'd2,
    FUNC_NONE   = 2'd3
  } func_t;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LIN,
    ST_BIN_CHK,
    ST_BIN_CMP,
    ST_DONE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_we;
    logic start;
    logic lin_step;
    logic bin_probe;
    logic bin_narrow;
    logic res_hit_lin;
    logic res_hit_bin;
    logic res_miss;
    logic out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic lin_hit;
    logic lin_more;
    logic bin_more;
    logic bin_hit;
  } status_t;

endpackage

// ===== rtl/alb_ram.sv =====
module alb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/alb_datapath.sv =====
module alb_datapath #(
  parameter int DEPTH = 1024
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  alb_pkg::cmd_t                       cmd,
  output alb_pkg::status_t                    status,
  input  logic                                cfg_we,
  input  logic [alb_pkg::CNT_W-1:0]           cfg_value,
  input  logic [alb_pkg::IDX_W-1:0]           load_index,
  input  logic signed [alb_pkg::VAL_W-1:0]    load_value,
  input  logic signed [alb_pkg::VAL_W-1:0]    search_key,
  output logic                                found,
  output logic [alb_pkg::POS_W-1:0]           position,
  output logic [alb_pkg::PRB_W-1:0]           probes
);
  import alb_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int NB = $clog2(DEPTH + 1);
  localparam int NW = (NB > CNT_W) ? NB : CNT_W;
  localparam logic [NW-1:0] DEPTH_N = NW'(DEPTH);

  logic [CNT_W-1:0]        count_r;
  logic [NW-1:0]           n_eff;
  logic signed [VAL_W-1:0] key_r;
  logic [NW-1:0]           i_r;
  logic                    pend_r;
  logic [NW-1:0]           pend_idx_r;
  logic signed [NW:0]      lo_r;
  logic signed [NW:0]      hi_r;
  logic [NW-1:0]           mid_r;
  logic [NW:0]             sum_c;
  logic [NW-1:0]           mid_c;
  logic [PRB_W-1:0]        probes_r;
  logic                    res_found_r;
  logic [POS_W-1:0]        res_pos_r;
  logic [PRB_W-1:0]        res_prb_r;
  logic                    found_r;
  logic [POS_W-1:0]        position_r;
  logic [PRB_W-1:0]        probes_out_r;
  logic                    load_ok;
  logic [AW-1:0]           raddr;
  logic signed [VAL_W-1:0] rdata;
  logic [VAL_W-1:0]        rdata_u;

  // Element count register; the search range saturates at the store depth.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= COUNT_RESET;
    end else if (cfg_we) begin
      count_r <= cfg_value;
    end
  end

  assign n_eff = (NW'(count_r) > DEPTH_N) ? DEPTH_N : NW'(count_r);

  // Loads beyond the store are dropped.
  assign load_ok = (NW'(load_index) < DEPTH_N) && cmd.load_we;

  // Floor midpoint of the current range; both bounds are non-negative here.
  assign sum_c = (NW + 1)'(lo_r) + (NW + 1)'(hi_r);
  assign mid_c = sum_c[NW:1];

  assign raddr = cmd.bin_probe ? mid_c[AW-1:0] : i_r[AW-1:0];

  alb_ram #(
    .WIDTH(VAL_W),
    .DEPTH(DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (load_ok),
    .waddr(AW'(load_index)),
    .wdata(load_value),
    .raddr(raddr),
    .rdata(rdata_u)
  );

  assign rdata = $signed(rdata_u);

  // Search state: key, linear cursor, binary bounds and probe count.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      key_r    <= search_key;
      i_r      <= '0;
      lo_r     <= '0;
      hi_r     <= $signed({1'b0, n_eff}) - (NW + 1)'(1);
      probes_r <= '0;
    end else begin
      if (cmd.lin_step) begin
        i_r <= i_r + NW'(1);
      end
      if (cmd.bin_probe) begin
        mid_r <= mid_c;
        if (probes_r != PROBES_MAX) begin
          probes_r <= probes_r + PRB_W'(1);
        end
      end
      if (cmd.bin_narrow) begin
        if (key_r > rdata) begin
          lo_r <= $signed({1'b0, mid_r}) + (NW + 1)'(1);
        end else begin
          hi_r <= $signed({1'b0, mid_r}) - (NW + 1)'(1);
        end
      end
    end
  end

  // A linear read issued last cycle is compared against the key this cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
    end else begin
      pend_r <= cmd.lin_step;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.lin_step) begin
      pend_idx_r <= i_r;
    end
  end

  assign status.lin_hit  = pend_r && (rdata == key_r);
  assign status.lin_more = (i_r < n_eff);
  assign status.bin_more = (lo_r <= hi_r);
  assign status.bin_hit  = (rdata == key_r);

  // Finished result, held until the output register is free.
  always_ff @(posedge clk) begin
    if (cmd.res_hit_lin) begin
      res_found_r <= 1'b1;
      res_pos_r   <= POS_W'(pend_idx_r);
      res_prb_r   <= '0;
    end else if (cmd.res_hit_bin) begin
      res_found_r <= 1'b1;
      res_pos_r   <= POS_W'(mid_r);
      res_prb_r   <= probes_r;
    end else if (cmd.res_miss) begin
      res_found_r <= 1'b0;
      res_pos_r   <= '0;
      res_prb_r   <= probes_r;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      found_r      <= res_found_r;
      position_r   <= res_pos_r;
      probes_out_r <= res_prb_r;
    end
  end

  assign found    = found_r;
  assign position = position_r;
  assign probes   = probes_out_r;

endmodule

// ===== rtl/alb_ctrl.sv =====
module alb_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [alb_pkg::FUNC_W-1:0]    in_func,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  input  alb_pkg::status_t              status,
  output alb_pkg::cmd_t                 cmd
);
  import alb_pkg::*;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;
  logic   accept;

  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;

  // State and output-valid registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    out_valid_nxt = out_valid_r && !out_tready;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (func_t'(in_func))
            FUNC_LOAD: begin
              cmd.load_we = 1'b1;
            end
            FUNC_LINEAR: begin
              cmd.start = 1'b1;
              state_nxt = ST_LIN;
            end
            FUNC_BINARY: begin
              cmd.start = 1'b1;
              state_nxt = ST_BIN_CHK;
            end
            default: begin
            end
          endcase
        end
      end
      ST_LIN: begin
        if (status.lin_hit) begin
          cmd.res_hit_lin = 1'b1;
          state_nxt       = ST_DONE;
        end else if (status.lin_more) begin
          cmd.lin_step = 1'b1;
        end else begin
          cmd.res_miss = 1'b1;
          state_nxt    = ST_DONE;
        end
      end
      ST_BIN_CHK: begin
        if (status.bin_more) begin
          cmd.bin_probe = 1'b1;
          state_nxt     = ST_BIN_CMP;
        end else begin
          cmd.res_miss = 1'b1;
          state_nxt    = ST_DONE;
        end
      end
      ST_BIN_CMP: begin
        if (status.bin_hit) begin
          cmd.res_hit_bin = 1'b1;
          state_nxt       = ST_DONE;
        end else begin
          cmd.bin_narrow = 1'b1;
          state_nxt      = ST_BIN_CHK;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_tvalid = out_valid_r;

endmodule

// ===== rtl/array_linear_binary_search.sv =====
// Searchable store of signed 32-bit elements.
// Input channel (in_*): one beat per item. tuser selects the operation:
// load an element, linear search or binary search; the unused code is
// dropped. A load writes the store in the cycle it is accepted.
// Result channel (out_*): one beat per search item with found, position
// and probe count. Loads give no result beat.
// Configuration channel (cfg_*): writes the element count; always ready.
// A linear search makes one store read per cycle through the single
// read port. A binary search waits, for each probe, on the registered
// store read before narrowing the range.
// Items are worked one at a time; the next item is accepted once the
// current result has moved into the output register, so a stalled
// receiver holds at most one waiting result while the next search runs.
// Reset clears the controller and sets the element count to 1; the store
// contents are left as they are and must be loaded before searching.
module array_linear_binary_search #(
  parameter int DEPTH = 1024
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // in_tdata: load_index[9:0], load_value[41:10], search_key[73:42], zero fill
  input  logic [79:0]                         in_tdata,
  // in_tuser: func[1:0]
  input  logic [alb_pkg::FUNC_W-1:0]          in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // out_tdata: found[0], position[10:1], probes[14:11], zero fill
  output logic [15:0]                         out_tdata,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [alb_pkg::CNT_W-1:0]           cfg_data
);
  import alb_pkg::*;

  cmd_t             cmd;
  status_t          status;
  logic             found;
  logic [POS_W-1:0] position;
  logic [PRB_W-1:0] probes;

  assign cfg_ready = 1'b1;

  alb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_func   (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .status    (status),
    .cmd       (cmd)
  );

  alb_datapath #(
    .DEPTH(DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .status    (status),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_value (cfg_data),
    .load_index(in_tdata[9:0]),
    .load_value($signed(in_tdata[41:10])),
    .search_key($signed(in_tdata[73:42])),
    .found     (found),
    .position  (position),
    .probes    (probes)
  );

  // Pack the result fields, lowest field first.
  assign out_tdata = {1'b0, probes, position, found};

endmodule
